### src/fdec_pkg.sv
// Package for the XOR checked frame decoder.
// Holds the parser phase and readout state types, status codes and the job and result records.
// No dependencies.
`default_nettype none

package fdec_pkg;

    localparam logic [7:0] START_BYTE = 8'hFE;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_FUNC_HI,
        PH_FUNC_LO,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_DATA,
        PH_CHECK
    } t_phase;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SINGLE,
        B_READ,
        B_LOAD
    } t_back_state;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_LONG = 2'd2
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [15:0] func;
        logic [15:0] len;
        logic        bank;
    } t_job;

    typedef struct packed {
        t_status     status;
        logic [15:0] func;
        logic [15:0] len;
        logic [5:0]  idx;
        logic [7:0]  data;
        logic        has;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

### src/fdec_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module fdec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### src/fdec_front.sv
// Front part of the frame decoder: parses received bytes, writes payload into a RAM bank
// and pushes one job per frame. Depends on fdec_pkg.
`default_nettype none

module fdec_front
    import fdec_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64,
    parameter int IW = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_rx_byte,
    input  wire logic          i_q_full,
    input  wire logic          i_banks_full,
    output logic               o_push,
    output t_job               o_job,
    output logic               o_bank_take,
    output logic               o_wr_en,
    output logic [IW:0]        o_wr_addr,
    output logic [7:0]         o_wr_data
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_func, n_func;
    logic [15:0] r_len, n_len;
    logic [15:0] r_count, n_count;
    logic [7:0]  r_check, n_check;
    logic        r_wbank, n_wbank;
    logic        accept;
    logic        len_over;
    logic [15:0] count_inc;
    t_status     chk_status;

    assign len_over   = r_len > 16'(MAX_PAYLOAD);
    assign count_inc  = r_count + 16'd1;
    assign accept     = i_valid && o_ready;
    assign chk_status = len_over ? ST_LONG : ((r_check != i_rx_byte) ? ST_BAD : ST_OK);

    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            case (r_phase)
                PH_WAIT:    if (i_rx_byte == START_BYTE) n_phase = PH_FUNC_HI;
                PH_FUNC_HI: n_phase = PH_FUNC_LO;
                PH_FUNC_LO: n_phase = PH_LEN_HI;
                PH_LEN_HI:  n_phase = PH_LEN_LO;
                PH_LEN_LO:  n_phase = ({r_len[15:8], i_rx_byte} == 16'd0) ? PH_CHECK : PH_DATA;
                PH_DATA:    if (count_inc >= r_len) n_phase = PH_CHECK;
                PH_CHECK:   n_phase = PH_WAIT;
                default:    n_phase = PH_WAIT;
            endcase
        end
    end

    always_comb begin
        n_func      = r_func;
        n_len       = r_len;
        n_count     = r_count;
        n_check     = r_check;
        n_wbank     = r_wbank;
        o_push      = 1'b0;
        o_bank_take = 1'b0;
        o_wr_en     = 1'b0;
        o_job       = '{status: chk_status, func: r_func, len: r_len, bank: r_wbank};
        o_wr_addr   = {r_wbank, r_count[IW-1:0]};
        o_wr_data   = i_rx_byte;
        case (r_phase)
            PH_CHECK: o_ready = !i_q_full;
            PH_DATA:  o_ready = len_over || !i_banks_full;
            default:  o_ready = 1'b1;
        endcase
        if (accept) begin
            case (r_phase)
                PH_WAIT: begin
                    if (i_rx_byte == START_BYTE) begin
                        n_check = START_BYTE;
                        n_count = 16'd0;
                    end
                end
                PH_FUNC_HI: begin
                    n_func  = {i_rx_byte, 8'd0};
                    n_check = r_check ^ i_rx_byte;
                end
                PH_FUNC_LO: begin
                    n_func  = {r_func[15:8], i_rx_byte};
                    n_check = r_check ^ i_rx_byte;
                end
                PH_LEN_HI: begin
                    n_len   = {i_rx_byte, 8'd0};
                    n_check = r_check ^ i_rx_byte;
                end
                PH_LEN_LO: begin
                    n_len   = {r_len[15:8], i_rx_byte};
                    n_check = r_check ^ i_rx_byte;
                    n_count = 16'd0;
                end
                PH_DATA: begin
                    o_wr_en = !len_over;
                    n_check = r_check ^ i_rx_byte;
                    n_count = count_inc;
                end
                PH_CHECK: begin
                    o_push  = 1'b1;
                    n_count = 16'd0;
                    if (chk_status == ST_OK && r_len != 16'd0) begin
                        o_bank_take = 1'b1;
                        n_wbank     = !r_wbank;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_func  <= 16'd0;
            r_len   <= 16'd0;
            r_count <= 16'd0;
            r_check <= START_BYTE;
            r_wbank <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_func  <= n_func;
            r_len   <= n_len;
            r_count <= n_count;
            r_check <= n_check;
            r_wbank <= n_wbank;
        end
    end

endmodule

`default_nettype wire

### src/fdec_queue.sv
// Two-entry job queue between the parser and the readout part.
// Depends on fdec_pkg.
`default_nettype none

module fdec_queue
    import fdec_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_job      o_job
);

    t_job       r_slot [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_job   = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wptr <= !r_wptr;
            if (i_pop)  r_rptr <= !r_rptr;
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("job pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("job popped from empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");

endmodule

`default_nettype wire

### src/fdec_back.sv
// Back part of the frame decoder: takes jobs from the queue and emits result items,
// reading payload bytes from the RAM bank of the job. Depends on fdec_pkg.
`default_nettype none

module fdec_back
    import fdec_pkg::*;
#(
    parameter int IW = 6
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_job_valid,
    input  wire t_job       i_job,
    output logic            o_pop,
    output logic            o_rd_en,
    output logic [IW:0]     o_rd_addr,
    input  wire logic [7:0] i_rd_data,
    output logic            o_release,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_result         o_result
);

    t_back_state r_state, n_state;
    t_job        r_job;
    logic [5:0]  r_k;
    logic        r_out_valid;
    t_result     r_out;
    logic        out_free;
    logic        is_last;
    logic        load_out;
    t_result     load_val;
    logic        job_single;

    assign out_free   = !r_out_valid || i_ready;
    assign is_last    = (16'(r_k) + 16'd1) == r_job.len;
    assign job_single = (i_job.status != ST_OK) || (i_job.len == 16'd0);
    assign o_rd_addr  = {r_job.bank, r_k[IW-1:0]};
    assign o_valid    = r_out_valid;
    assign o_result   = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:   if (i_job_valid) n_state = job_single ? B_SINGLE : B_READ;
            B_SINGLE: if (out_free) n_state = B_IDLE;
            B_READ:   n_state = B_LOAD;
            B_LOAD:   if (out_free) n_state = is_last ? B_IDLE : B_READ;
            default:  n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        o_rd_en   = 1'b0;
        o_release = 1'b0;
        load_out  = 1'b0;
        load_val  = '{status: r_job.status, func: r_job.func, len: r_job.len,
                      idx: 6'd0, data: 8'd0, has: 1'b0, last: 1'b1};
        case (r_state)
            B_IDLE:   o_pop = i_job_valid;
            B_SINGLE: load_out = out_free;
            B_READ:   o_rd_en = 1'b1;
            B_LOAD: begin
                load_out      = out_free;
                o_release     = out_free && is_last;
                load_val.idx  = r_k;
                load_val.data = i_rd_data;
                load_val.has  = 1'b1;
                load_val.last = is_last;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (load_out) begin
            r_out <= load_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_k         <= 6'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_k <= 6'd0;
            end else if (r_state == B_LOAD && out_free) begin
                r_k <= r_k + 6'd1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### src/xor_checked_frame_decoder_top.sv
// Top level of the XOR checked frame decoder: parser, job queue, two-bank payload RAM
// and readout. Depends on fdec_pkg, fdec_front, fdec_queue, fdec_ram and fdec_back.
//
// The decoder takes one received byte per cycle. It waits only at a checksum byte while its
// two-entry job queue is full, and at a stored payload byte while both payload banks still
// hold frames not yet read out. A frame is reported through the job queue once its checksum
// byte is taken; a good frame then gives one result per payload byte (RAM read, then output
// register), and an error or empty frame gives its single result. Bytes of the next frame are
// taken while an earlier frame is still being read out.
`default_nettype none

module xor_checked_frame_decoder_top
    import fdec_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [15:0]      o_function_code,
    output logic [15:0]      o_payload_length,
    output logic [5:0]       o_byte_index,
    output logic [7:0]       o_payload_byte,
    output logic             o_has_byte,
    output logic             o_last
);

    localparam int IW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int RAM_DEPTH = 2 ** (IW + 1);

    logic        q_full, q_valid, push, pop;
    t_job        push_job, pop_job;
    logic        bank_take, bank_release;
    logic [1:0]  r_banks_used;
    logic        wr_en, rd_en;
    logic [IW:0] wr_addr, rd_addr;
    logic [7:0]  wr_data, rd_data;
    t_result     result;

    fdec_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD),
        .IW(IW)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_rx_byte(i_rx_byte),
        .i_q_full(q_full),
        .i_banks_full(r_banks_used == 2'd2),
        .o_push(push),
        .o_job(push_job),
        .o_bank_take(bank_take),
        .o_wr_en(wr_en),
        .o_wr_addr(wr_addr),
        .o_wr_data(wr_data)
    );

    fdec_queue u_queue (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(push),
        .i_job(push_job),
        .o_full(q_full),
        .i_pop(pop),
        .o_valid(q_valid),
        .o_job(pop_job)
    );

    fdec_ram #(
        .WIDTH(8),
        .DEPTH(RAM_DEPTH)
    ) u_ram (
        .i_clk(i_clk),
        .i_wr_en(wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en(rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    fdec_back #(
        .IW(IW)
    ) u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_job_valid(q_valid),
        .i_job(pop_job),
        .o_pop(pop),
        .o_rd_en(rd_en),
        .o_rd_addr(rd_addr),
        .i_rd_data(rd_data),
        .o_release(bank_release),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_result(result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_banks_used <= 2'd0;
        end else begin
            r_banks_used <= r_banks_used + 2'(bank_take) - 2'(bank_release);
        end
    end

    assign o_status         = result.status;
    assign o_function_code  = result.func;
    assign o_payload_length = result.len;
    assign o_byte_index     = result.idx;
    assign o_payload_byte   = result.data;
    assign o_has_byte       = result.has;
    assign o_last           = result.last;

endmodule

`default_nettype wire

### sim/fdec_frame_checker.sv
// Checker for the XOR checked frame decoder: watches both channels, predicts every result from
// the accepted bytes and compares it field by field. Depends on fdec_pkg.
module fdec_frame_checker
    import fdec_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [1:0]  i_status,
    input  wire logic [15:0] i_function_code,
    input  wire logic [15:0] i_payload_length,
    input  wire logic [5:0]  i_byte_index,
    input  wire logic [7:0]  i_payload_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_last,
    output int               o_mismatches,
    output int               o_pending
);

    t_phase      parse_phase;
    logic [15:0] func_reg;
    logic [15:0] len_reg;
    logic [15:0] byte_cnt;
    logic [7:0]  running_xor;
    logic [7:0]  payload_mem [64];
    t_result     expected_results [$];

    task automatic decode_byte(input logic [7:0] c);
        t_result r;
        r.status = ST_OK;
        r.func   = func_reg;
        r.len    = len_reg;
        r.idx    = '0;
        r.data   = '0;
        r.has    = 1'b0;
        r.last   = 1'b1;
        case (parse_phase)
            PH_WAIT: begin
                if (c == START_BYTE) begin
                    running_xor = START_BYTE;
                    byte_cnt    = '0;
                    parse_phase = PH_FUNC_HI;
                end
            end
            PH_FUNC_HI: begin
                func_reg    = {c, 8'h00};
                running_xor ^= c;
                parse_phase = PH_FUNC_LO;
            end
            PH_FUNC_LO: begin
                func_reg    = {func_reg[15:8], c};
                running_xor ^= c;
                parse_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                len_reg     = {c, 8'h00};
                running_xor ^= c;
                parse_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                len_reg     = {len_reg[15:8], c};
                running_xor ^= c;
                byte_cnt    = '0;
                parse_phase = (len_reg == 16'd0) ? PH_CHECK : PH_DATA;
            end
            PH_DATA: begin
                if (len_reg <= MAX_PAYLOAD) begin
                    payload_mem[byte_cnt[5:0]] = c;
                end
                running_xor ^= c;
                byte_cnt    = byte_cnt + 16'd1;
                if (byte_cnt >= len_reg) begin
                    parse_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                if (len_reg > MAX_PAYLOAD) begin
                    r.status = ST_LONG;
                    expected_results.push_back(r);
                end else if (running_xor != c) begin
                    r.status = ST_BAD;
                    expected_results.push_back(r);
                end else if (len_reg == 16'd0) begin
                    expected_results.push_back(r);
                end else begin
                    for (int k = 0; k < len_reg; k++) begin
                        r.idx  = k[5:0];
                        r.data = payload_mem[k[5:0]];
                        r.has  = 1'b1;
                        r.last = (k + 1 == len_reg);
                        expected_results.push_back(r);
                    end
                end
                byte_cnt    = '0;
                parse_phase = PH_WAIT;
            end
            default: begin
                parse_phase = PH_WAIT;
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            o_mismatches++;
        end
    endtask

    task automatic check_result();
        t_result want;
        if (expected_results.size() == 0) begin
            $error("unexpected result: status %0d, index %0d, byte %0h",
                   i_status, i_byte_index, i_payload_byte);
            o_mismatches++;
        end else begin
            want = expected_results.pop_front();
            compare_field("status", want.status, i_status);
            compare_field("function_code", want.func, i_function_code);
            compare_field("payload_length", want.len, i_payload_length);
            compare_field("byte_index", want.idx, i_byte_index);
            compare_field("payload_byte", want.data, i_payload_byte);
            compare_field("has_byte", want.has, i_has_byte);
            compare_field("last", want.last, i_last);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            parse_phase  = PH_WAIT;
            func_reg     = '0;
            len_reg      = '0;
            byte_cnt     = '0;
            running_xor  = START_BYTE;
            o_mismatches = 0;
            foreach (payload_mem[k]) begin
                payload_mem[k] = '0;
            end
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_result();
            end
            if (i_in_valid && i_in_ready) begin
                decode_byte(i_rx_byte);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

### sim/tb_xor_checked_frame_decoder_top.sv
// Testbench top for the XOR checked frame decoder: makes reset, clock and byte stimulus,
// applies backpressure and gives the verdict. Depends on fdec_pkg, the decoder and the checker.
module tb_xor_checked_frame_decoder_top;
    import fdec_pkg::*;

    localparam int MAX_PAYLOAD  = 64;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_ready = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_ready;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [15:0] o_function_code;
    logic [15:0] o_payload_length;
    logic [5:0]  o_byte_index;
    logic [7:0]  o_payload_byte;
    logic        o_has_byte;
    logic        o_last;

    int mismatches;
    int pending;
    int items_sent = 0;
    int cycle_count = 0;
    int stall_left = 0;
    bit gaps_on = 1'b0;

    logic [7:0] directed_bytes [] = '{
        8'h00, 8'hFF,
        8'hFE, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFE,
        8'hFE, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFE, 8'h01,
        8'hFE, 8'h12, 8'h34, 8'h00, 8'h02, 8'hAB, 8'h55, 8'h25
    };

    always #1 i_clk = ~i_clk;

    xor_checked_frame_decoder_top #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_rx_byte(i_rx_byte),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_status(o_status),
        .o_function_code(o_function_code),
        .o_payload_length(o_payload_length),
        .o_byte_index(o_byte_index),
        .o_payload_byte(o_payload_byte),
        .o_has_byte(o_has_byte),
        .o_last(o_last)
    );

    fdec_frame_checker #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) frame_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_valid),
        .i_in_ready(o_ready),
        .i_rx_byte(i_rx_byte),
        .i_out_valid(o_valid),
        .i_out_ready(i_ready),
        .i_status(o_status),
        .i_function_code(o_function_code),
        .i_payload_length(o_payload_length),
        .i_byte_index(o_byte_index),
        .i_payload_byte(o_payload_byte),
        .i_has_byte(o_has_byte),
        .i_last(o_last),
        .o_mismatches(mismatches),
        .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 3);
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame(input logic [15:0] func, input logic [15:0] len,
                              input bit corrupt);
        logic [7:0] sum;
        logic [7:0] b;
        sum = START_BYTE ^ func[15:8] ^ func[7:0] ^ len[15:8] ^ len[7:0];
        send_byte(START_BYTE);
        send_byte(func[15:8]);
        send_byte(func[7:0]);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        for (int k = 0; k < len; k++) begin
            b = 8'($urandom_range(0, 255));
            sum ^= b;
            send_byte(b);
        end
        if (corrupt) begin
            sum ^= 8'($urandom_range(1, 255));
        end
        send_byte(sum);
    endtask

    task automatic send_noise();
        logic [7:0] b;
        repeat ($urandom_range(1, 3)) begin
            b = 8'($urandom_range(0, 254));
            if (b == START_BYTE) begin
                b = 8'hFF;
            end
            send_byte(b);
        end
    endtask

    function automatic logic [15:0] pick_length();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 10) begin
            return 16'd0;
        end else if (sel < 75) begin
            return 16'($urandom_range(1, 8));
        end else if (sel < 85) begin
            return 16'($urandom_range(9, MAX_PAYLOAD));
        end else if (sel < 95) begin
            return 16'($urandom_range(MAX_PAYLOAD + 1, MAX_PAYLOAD + 8));
        end
        return 16'(MAX_PAYLOAD);
    endfunction

    task automatic send_random_frame();
        if ($urandom_range(0, 4) == 0) begin
            send_noise();
        end
        send_frame(16'($urandom_range(0, 65535)), pick_length(), $urandom_range(0, 4) == 0);
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        gaps_on = 1'b1;
        foreach (directed_bytes[k]) begin
            send_byte(directed_bytes[k]);
        end

        // Let the decoder drain completely before the random part starts.
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);

        send_frame(16'($urandom_range(0, 65535)), 16'(MAX_PAYLOAD), 1'b0);
        while (items_sent < 170) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            send_random_frame();
        end

        gaps_on = 1'b0;
        while (items_sent < 200) begin
            send_random_frame();
        end
        i_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### xor_checked_frame_decoder_top.f
src/fdec_pkg.sv
src/fdec_ram.sv
src/fdec_front.sv
src/fdec_queue.sv
src/fdec_back.sv
src/xor_checked_frame_decoder_top.sv
sim/fdec_frame_checker.sv
sim/tb_xor_checked_frame_decoder_top.sv
